// ===== hw/rtl/voice_slot_allocator_with_stealing_defines.svh =====
// assertion macros used by the voice slot allocator datapath
`ifndef VOICE_SLOT_ALLOCATOR_WITH_STEALING_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_WITH_STEALING_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vsa_pkg.sv =====
// shared types and constants of the voice slot allocator
package vsa_pkg;

    localparam int DEF_SLOT_COUNT  = 8;
    localparam int DEF_CURSOR_BITS = 24;
    localparam int DEF_ID_BITS     = 16;

    localparam int OP_W     = 2;
    localparam int PID_W    = 16;
    localparam int SND_W    = 8;
    localparam int CUR_W    = 24;
    localparam int SEL_W    = 3;
    localparam int STAT_W   = 3;
    localparam int SLOT_W   = 3;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START      = 2'd0,
        OP_STOP       = 2'd1,
        OP_STOP_ALL   = 2'd2,
        OP_SET_CURSOR = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_STARTED_FREE   = 3'd0,
        ST_STARTED_STOLEN = 3'd1,
        ST_REFUSED        = 3'd2,
        ST_STOPPED        = 3'd3,
        ST_STOP_MISSED    = 3'd4,
        ST_ALL_STOPPED    = 3'd5,
        ST_CURSOR_SET     = 3'd6
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== hw/rtl/vsa_ctrl.sv =====
// request sequencer: idle, slot scan, commit
module vsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  vsa_pkg::t_op     i_op,
    output vsa_pkg::t_dp_cmd o_cmd,
    input  vsa_pkg::t_dp_sts i_sts
);
    import vsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready   = (r_state == S_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign o_cmd.load   = w_accept;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_DONE) && !i_sts.out_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_START || i_op == OP_STOP) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/vsa_dp.sv =====
// slot tables, scan pipeline, commit logic and result register
`include "voice_slot_allocator_with_stealing_defines.svh"

module vsa_dp #(
    parameter int SLOT_COUNT  = vsa_pkg::DEF_SLOT_COUNT,
    parameter int CURSOR_BITS = vsa_pkg::DEF_CURSOR_BITS,
    parameter int ID_BITS     = vsa_pkg::DEF_ID_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vsa_pkg::t_dp_cmd            i_cmd,
    output vsa_pkg::t_dp_sts            o_sts,
    input  vsa_pkg::t_op                i_op,
    input  logic [vsa_pkg::PID_W-1:0]   i_pid,
    input  logic [vsa_pkg::SND_W-1:0]   i_snd,
    input  logic                        i_keep,
    input  logic [vsa_pkg::CUR_W-1:0]   i_cur,
    input  logic                        i_rewind,
    input  logic [vsa_pkg::SEL_W-1:0]   i_sel,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output vsa_pkg::t_status            o_status,
    output logic [vsa_pkg::SLOT_W-1:0]  o_slot,
    output logic [vsa_pkg::CUR_W-1:0]   o_cursor
);
    import vsa_pkg::*;

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int META_W = SND_W + 1 + ID_BITS;

    // request
    t_op                 r_op;
    logic [PID_W-1:0]    r_pid;
    logic [SND_W-1:0]    r_snd;
    logic                r_keep;
    logic [CUR_W-1:0]    r_cur;
    logic                r_rewind;
    logic [SEL_W-1:0]    r_sel;

    // slot state
    logic [SLOT_COUNT-1:0]  r_playing;
    logic [CURSOR_BITS-1:0] r_cur_mem  [SLOT_COUNT];
    logic [META_W-1:0]      r_meta_mem [SLOT_COUNT];
    logic [CURSOR_BITS-1:0] r_cur_rd;
    logic [META_W-1:0]      r_meta_rd;

    // scan
    logic [CNT_W-1:0]       r_rd_idx;
    logic                   r_ev_vld;
    logic [IDX_W-1:0]       r_ev_idx;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_tgt;
    logic [CURSOR_BITS-1:0] r_hit_cur;
    logic                   r_vic_vld;
    logic [IDX_W-1:0]       r_vic;
    logic [CURSOR_BITS-1:0] r_best;

    // result
    logic                r_out_vld;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [CUR_W-1:0]    r_out_cursor;

    logic                   w_issue;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_eval;
    logic                   w_ev_play;
    logic                   w_ev_keep;
    logic [ID_BITS-1:0]     w_ev_owner;
    logic                   w_free_hit;
    logic                   w_stop_hit;
    logic                   w_vic_upd;

    logic                   w_start_ok;
    logic [IDX_W-1:0]       w_tgt;
    logic [IDX_W+2:0]       w_tgt_wide;
    logic [IDX_W+2:0]       w_sel_wide;
    logic                   w_sel_ok;
    logic [CURSOR_BITS+CUR_W-1:0] w_hc_wide;
    logic                   w_cur_we;
    logic [IDX_W-1:0]       w_cur_waddr;
    logic [CURSOR_BITS-1:0] w_cur_wdata;
    logic                   w_meta_we;
    logic                   w_play_set;
    logic                   w_play_clr;
    logic                   w_play_clr_all;
    t_status                w_status;
    logic [SLOT_W-1:0]      w_slot;
    logic [CUR_W-1:0]       w_cursor;

    // scan pipeline: address issue, registered read, evaluate
    assign w_rd_addr = r_rd_idx[IDX_W-1:0];
    assign w_issue   = i_cmd.scan && !r_hit && (r_rd_idx != CNT_W'(SLOT_COUNT));
    assign w_eval    = i_cmd.scan && r_ev_vld && !r_hit;

    assign w_ev_play  = r_playing[r_ev_idx];
    assign w_ev_owner = r_meta_rd[ID_BITS-1:0];
    assign w_ev_keep  = r_meta_rd[ID_BITS];

    assign w_free_hit = w_eval && (r_op == OP_START) && !w_ev_play;
    assign w_stop_hit = w_eval && (r_op == OP_STOP) && w_ev_play
                        && (w_ev_owner == ID_BITS'(r_pid));
    assign w_vic_upd  = w_eval && (r_op == OP_START) && w_ev_play && !w_ev_keep
                        && (!r_vic_vld || (r_cur_rd > r_best));

    assign o_sts.scan_done = r_hit || ((r_rd_idx == CNT_W'(SLOT_COUNT)) && !r_ev_vld);
    assign o_sts.out_full  = r_out_vld && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_pid    <= i_pid;
            r_snd    <= i_snd;
            r_keep   <= i_keep;
            r_cur    <= i_cur;
            r_rewind <= i_rewind;
            r_sel    <= i_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_vic_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_vic_vld <= 1'b0;
        end else begin
            r_ev_vld <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (w_free_hit || w_stop_hit) begin
                r_hit <= 1'b1;
            end
            if (w_vic_upd) begin
                r_vic_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_ev_idx  <= w_rd_addr;
            r_cur_rd  <= r_cur_mem[w_rd_addr];
            r_meta_rd <= r_meta_mem[w_rd_addr];
        end
        if (w_free_hit || w_stop_hit) begin
            r_tgt     <= r_ev_idx;
            r_hit_cur <= r_cur_rd;
        end
        if (w_vic_upd) begin
            r_vic  <= r_ev_idx;
            r_best <= r_cur_rd;
        end
    end

    // commit decode
    assign w_start_ok = r_hit || r_vic_vld;
    assign w_tgt      = r_hit ? r_tgt : r_vic;
    assign w_tgt_wide = (IDX_W + 3)'(w_tgt);
    assign w_sel_wide = (IDX_W + 3)'(r_sel);
    assign w_sel_ok   = 32'(r_sel) < 32'(SLOT_COUNT);
    assign w_hc_wide  = (CURSOR_BITS + CUR_W)'(r_hit_cur);

    always_comb begin
        w_cur_we       = 1'b0;
        w_cur_waddr    = w_tgt;
        w_cur_wdata    = CURSOR_BITS'(r_cur);
        w_meta_we      = 1'b0;
        w_play_set     = 1'b0;
        w_play_clr     = 1'b0;
        w_play_clr_all = 1'b0;
        w_status       = ST_REFUSED;
        w_slot         = '0;
        w_cursor       = '0;
        case (r_op)
            OP_START: begin
                if (w_start_ok) begin
                    w_cur_we   = 1'b1;
                    w_meta_we  = 1'b1;
                    w_play_set = 1'b1;
                    w_slot     = w_tgt_wide[SLOT_W-1:0];
                    w_status   = r_hit ? ST_STARTED_FREE : ST_STARTED_STOLEN;
                    if (r_rewind) begin
                        w_cur_wdata = '0;
                    end
                end
            end
            OP_STOP: begin
                if (r_hit) begin
                    w_play_clr = 1'b1;
                    w_status   = ST_STOPPED;
                    w_slot     = w_tgt_wide[SLOT_W-1:0];
                    w_cursor   = w_hc_wide[CUR_W-1:0];
                end else begin
                    w_status   = ST_STOP_MISSED;
                end
            end
            OP_STOP_ALL: begin
                w_play_clr_all = 1'b1;
                w_status       = ST_ALL_STOPPED;
            end
            OP_SET_CURSOR: begin
                w_cur_we    = w_sel_ok;
                w_cur_waddr = w_sel_wide[IDX_W-1:0];
                w_status    = ST_CURSOR_SET;
                w_slot      = r_sel;
            end
            default: begin
                w_status = ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_cur_we) begin
            r_cur_mem[w_cur_waddr] <= w_cur_wdata;
        end
        if (i_cmd.commit && w_meta_we) begin
            r_meta_mem[w_tgt] <= {r_snd, r_keep, ID_BITS'(r_pid)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= '0;
        end else if (i_cmd.commit) begin
            if (w_play_clr_all) begin
                r_playing <= '0;
            end else if (w_play_set) begin
                r_playing[w_tgt] <= 1'b1;
            end else if (w_play_clr) begin
                r_playing[w_tgt] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_slot   <= w_slot;
            r_out_cursor <= w_cursor;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_status   = r_out_status;
    assign o_slot     = r_out_slot;
    assign o_cursor   = r_out_cursor;

    `VSA_ASSERT_NOW(a_commit_no_overwrite, i_cmd.commit, !(r_out_vld && !i_m_tready), "result overwritten before taken")
    `VSA_ASSERT_NEXT(a_commit_gives_result, i_cmd.commit, r_out_vld, "commit without result")
    `VSA_ASSERT_NOW(a_hit_needs_scan_op, r_hit, (r_op == OP_START) || (r_op == OP_STOP), "scan hit on non-scan op")
    `VSA_ASSERT_NOW(a_stop_hit_playing, $rose(r_hit) && (r_op == OP_STOP), r_playing[r_tgt], "stop hit on idle slot")

endmodule

// ===== hw/rtl/voice_slot_allocator_with_stealing.sv =====
// top level of the voice slot allocator with stealing
//
// channel  dir  tdata (low bit up)                                 tuser
// -------  ---  -------------------------------------------------  ---------------
// s        in   voice_id[15:0] sound_id[23:16] no_steal[24]         operation[1:0]
//               cursor_value[48:25] reset_to_start[49]
//               slot_select[52:50], zero fill to 56
// m        out  slot_index[2:0] cursor_out[26:3], zero fill to 32   status[2:0]
//
// start and stop walk the slots one per cycle through the registered read of the
// slot tables, the whole pool when nothing ends the walk, stopping early when a
// free slot (start) or a playing slot with the matching id (stop) turns up
// stop-all and set-cursor skip the scan and go from the accept straight to commit
// synchronous active-low reset clears the playing flags and the control state,
// the per-slot tables are only used for playing slots and need no clearing
// a stalled result sits in the output register, the next request is taken and
// scanned meanwhile but its commit waits until the register empties
module voice_slot_allocator_with_stealing #(
    parameter int SLOT_COUNT  = vsa_pkg::DEF_SLOT_COUNT,
    parameter int CURSOR_BITS = vsa_pkg::DEF_CURSOR_BITS,
    parameter int ID_BITS     = vsa_pkg::DEF_ID_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // voice_id, sound_id, no_steal, cursor_value, reset_to_start, slot_select
    input  logic [vsa_pkg::S_DATA_W-1:0]   i_s_tdata,
    // operation
    input  logic [vsa_pkg::OP_W-1:0]       i_s_tuser,
    // result channel
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // slot_index, cursor_out
    output logic [vsa_pkg::M_DATA_W-1:0]   o_m_tdata,
    // status
    output logic [vsa_pkg::STAT_W-1:0]     o_m_tuser
);
    import vsa_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    t_op                w_op;
    t_status            w_status;
    logic [SLOT_W-1:0]  w_slot;
    logic [CUR_W-1:0]   w_cursor;

    // request fields unpacked from the transaction
    assign w_op = t_op'(i_s_tuser);

    vsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (w_op),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    vsa_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .CURSOR_BITS (CURSOR_BITS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_op       (w_op),
        .i_pid      (i_s_tdata[15:0]),
        .i_snd      (i_s_tdata[23:16]),
        .i_keep     (i_s_tdata[24]),
        .i_cur      (i_s_tdata[48:25]),
        .i_rewind   (i_s_tdata[49]),
        .i_sel      (i_s_tdata[52:50]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_slot     (w_slot),
        .o_cursor   (w_cursor)
    );

    // result fields packed into the transaction
    assign o_m_tdata = {(M_DATA_W - CUR_W - SLOT_W)'(0), w_cursor, w_slot};
    assign o_m_tuser = w_status;

endmodule

// ===== tb/sv/voice_slot_allocator_with_stealing_tb.sv =====
// self-checking stream testbench for the voice slot allocator with stealing
`timescale 1ns / 100ps

module voice_slot_allocator_with_stealing_tb;
    import vsa_pkg::*;

    localparam int               SLOT_COUNT   = DEF_SLOT_COUNT;
    localparam logic [CUR_W-1:0] CURSOR_MAX   = '1;
    localparam int               RANDOM_ITEMS = 1000;
    localparam int               HOLD_CYCLES  = 200;
    localparam int               DRAIN_CYCLES = 4 * (SLOT_COUNT + 4);
    localparam int               CYCLE_LIMIT  = 1000000;

    // one result as the block should report it
    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CUR_W-1:0]  cursor;
    } t_voice_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;  // voice_id, sound_id, no_steal, cursor_value,
                                     // reset_to_start, slot_select, zero fill
    logic [OP_W-1:0]     i_s_tuser;  // operation
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;  // slot_index, cursor_out, zero fill
    logic [STAT_W-1:0]   o_m_tuser;  // status

    // shadow copy of the slot pool
    logic              slot_busy  [SLOT_COUNT];
    logic              slot_pinned[SLOT_COUNT];
    logic [CUR_W-1:0]  slot_pos   [SLOT_COUNT];
    logic [PID_W-1:0]  slot_owner [SLOT_COUNT];
    logic [SND_W-1:0]  slot_sound [SLOT_COUNT];

    t_voice_result pending_results[$];
    int            error_count;
    int            cycle_count;
    bit            quiet_mode;     // no gaps on either side while set
    bit            hold_off_req;   // ask the result side for one long stall

    voice_slot_allocator_with_stealing uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // cursors cluster on the extremes and small values so that steals see ties
    function automatic logic [CUR_W-1:0] pick_cursor();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CURSOR_MAX;
            2: return CUR_W'($urandom_range(0, 3));
            default: return CUR_W'($urandom_range(0, CURSOR_MAX));
        endcase
    endfunction

    // owner id of some playing slot, so that most stops hit
    function automatic logic [PID_W-1:0] live_voice_id();
        int live[$];
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_busy[i]) live.push_back(i);
        if (live.size() == 0) return PID_W'($urandom_range(0, 65535));
        return slot_owner[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    // applies one request to the shadow pool and returns the result it must produce
    function automatic t_voice_result predict_voice_result(
        input t_op              op,
        input logic [PID_W-1:0] pid,
        input logic [SND_W-1:0] snd,
        input logic             keep,
        input logic [CUR_W-1:0] cur,
        input logic             rewind,
        input logic [SEL_W-1:0] sel
    );
        t_voice_result    res;
        bit               found;
        int               target;
        int               victim;
        logic [CUR_W-1:0] best;
        res.status = ST_CURSOR_SET;
        res.slot   = '0;
        res.cursor = '0;
        found      = 1'b0;
        target     = 0;
        victim     = -1;
        best       = '0;
        case (op)
            OP_START: begin
                // lowest idle slot wins, else the furthest unpinned cursor
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found) begin
                        if (!slot_busy[i]) begin
                            found  = 1'b1;
                            target = i;
                        end else if (!slot_pinned[i] && (victim < 0 || slot_pos[i] > best)) begin
                            victim = i;
                            best   = slot_pos[i];
                        end
                    end
                end
                res.status = ST_STARTED_FREE;
                if (!found) begin
                    target     = victim;
                    res.status = ST_STARTED_STOLEN;
                end
                if (!found && victim < 0) begin
                    res.status = ST_REFUSED;
                end else begin
                    slot_busy[target]   = 1'b1;
                    slot_pinned[target] = keep;
                    slot_pos[target]    = rewind ? '0 : cur;
                    slot_owner[target]  = pid;
                    slot_sound[target]  = snd;
                    res.slot            = target[SLOT_W-1:0];
                end
            end
            OP_STOP: begin
                res.status = ST_STOP_MISSED;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found && slot_busy[i] && slot_owner[i] == pid) begin
                        found        = 1'b1;
                        slot_busy[i] = 1'b0;
                        res.status   = ST_STOPPED;
                        res.slot     = i[SLOT_W-1:0];
                        res.cursor   = slot_pos[i];
                    end
                end
            end
            OP_STOP_ALL: begin
                for (int i = 0; i < SLOT_COUNT; i++) slot_busy[i] = 1'b0;
                res.status = ST_ALL_STOPPED;
            end
            default: begin
                // idle slots take the write too
                if (sel < SLOT_COUNT) slot_pos[sel] = cur;
                res.status = ST_CURSOR_SET;
                res.slot   = sel;
            end
        endcase
        return res;
    endfunction

    // offers one request after a random gap and returns once it is accepted
    task automatic send_request(
        input t_op              op,
        input logic [PID_W-1:0] pid,
        input logic [SND_W-1:0] snd,
        input logic             keep,
        input logic [CUR_W-1:0] cur,
        input logic             rewind,
        input logic [SEL_W-1:0] sel
    );
        int gap;
        gap = quiet_mode ? 0 : idle_cycles();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, sel, rewind, cur, keep, snd, pid};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // every accepted request transaction feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_results.push_back(predict_voice_result(t_op'(i_s_tuser),
                i_s_tdata[15:0], i_s_tdata[23:16], i_s_tdata[24],
                i_s_tdata[48:25], i_s_tdata[49], i_s_tdata[52:50]));
        end
    end

    // every accepted result transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_voice_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d cursor %0h",
                         $time, o_m_tuser, o_m_tdata[2:0], o_m_tdata[26:3]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata[2:0] !== want.slot) begin
                    $display("%0t: slot_index mismatch, expected %0d actual %0d",
                             $time, want.slot, o_m_tdata[2:0]);
                    error_count++;
                end
                if (o_m_tdata[26:3] !== want.cursor) begin
                    $display("%0t: cursor_out mismatch, expected %0h actual %0h",
                             $time, want.cursor, o_m_tdata[26:3]);
                    error_count++;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            int stall;
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                stall = quiet_mode ? 0 : idle_cycles();
                if (stall == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // fill the pool from empty; slot 7 gets its cursor while still idle
    task automatic test_free_starts();
        send_request(OP_SET_CURSOR, 16'h0000, 8'h00, 1'b0, CURSOR_MAX, 1'b0, 3'd7);
        send_request(OP_START, 16'h0000, 8'h00, 1'b0, 24'h000010, 1'b0, 3'd0);
        send_request(OP_START, 16'hFFFF, 8'hFF, 1'b1, CURSOR_MAX,  1'b0, 3'd7);
        send_request(OP_START, 16'h1234, 8'h5A, 1'b0, CURSOR_MAX,  1'b0, 3'd2);
        // rewind wins over the supplied cursor
        send_request(OP_START, 16'h0002, 8'hA5, 1'b0, 24'h123456, 1'b1, 3'd5);
        send_request(OP_START, 16'h0003, 8'h01, 1'b1, 24'h000005, 1'b0, 3'd0);
        send_request(OP_START, 16'h0004, 8'h80, 1'b0, CURSOR_MAX,  1'b0, 3'd1);
        send_request(OP_START, 16'h0005, 8'h7F, 1'b0, 24'h000000, 1'b0, 3'd6);
        send_request(OP_START, 16'h0006, 8'h33, 1'b0, 24'hABCDEF, 1'b0, 3'd3);
    endtask

    // pool is full: slots 2 and 5 tie on the largest cursor, lower index goes first
    task automatic test_stealing();
        send_request(OP_START, 16'h0007, 8'h11, 1'b1, 24'h000001, 1'b0, 3'd0);
        send_request(OP_START, 16'h0008, 8'h22, 1'b0, 24'h000009, 1'b0, 3'd0);
    endtask

    // stop hit, repeated stop that misses, stop of id zero
    task automatic test_stop_by_id();
        send_request(OP_STOP, 16'hFFFF, 8'h00, 1'b0, '0, 1'b0, 3'd0);
        send_request(OP_STOP, 16'hFFFF, 8'hFF, 1'b1, CURSOR_MAX, 1'b1, 3'd7);
        send_request(OP_STOP, 16'h0000, 8'h00, 1'b0, '0, 1'b0, 3'd0);
    endtask

    // write a playing slot and an idle one, then read the first back by stopping it
    task automatic test_set_cursor();
        send_request(OP_SET_CURSOR, 16'h0000, 8'h00, 1'b0, 24'h800000, 1'b0, 3'd3);
        send_request(OP_SET_CURSOR, 16'hFFFF, 8'hFF, 1'b1, 24'h7FFFFF, 1'b1, 3'd0);
        send_request(OP_STOP, 16'h0002, 8'h00, 1'b0, '0, 1'b0, 3'd0);
    endtask

    // every slot pinned, so the next start is refused
    task automatic test_refusal();
        send_request(OP_STOP_ALL, 16'h0000, 8'h00, 1'b0, '0, 1'b0, 3'd0);
        for (int i = 0; i < SLOT_COUNT; i++)
            send_request(OP_START, PID_W'(16'h0100 + i), SND_W'($urandom_range(0, 255)),
                         1'b1, pick_cursor(), 1'b0, 3'd0);
        send_request(OP_START, 16'h0200, 8'h00, 1'b0, '0, 1'b0, 3'd0);
    endtask

    // result side holds off while requests keep coming, so the input must stall
    task automatic test_output_backpressure();
        quiet_mode   = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_request((i % 3 == 2) ? OP_STOP : OP_START, live_voice_id(),
                         SND_W'($urandom_range(0, 255)), 1'b0, pick_cursor(), 1'b0,
                         SEL_W'($urandom_range(0, 7)));
        quiet_mode = 1'b0;
    endtask

    // mostly starts and stops of live ids, with stop-all and cursor writes mixed in
    task automatic test_random_traffic();
        int               roll;
        t_op              op;
        logic [PID_W-1:0] pid;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 45)      op = OP_START;
            else if (roll < 75) op = OP_STOP;
            else if (roll < 80) op = OP_STOP_ALL;
            else                op = OP_SET_CURSOR;
            // small id pool makes duplicate owners, full range exercises every bit
            if ($urandom_range(0, 1) == 0) pid = PID_W'($urandom_range(0, 15));
            else                           pid = PID_W'($urandom_range(0, 65535));
            if (op == OP_STOP && $urandom_range(0, 9) < 7) pid = live_voice_id();
            send_request(op, pid, SND_W'($urandom_range(0, 255)), $urandom_range(0, 9) < 3,
                         pick_cursor(), $urandom_range(0, 4) == 0,
                         SEL_W'($urandom_range(0, 7)));
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = OP_START;
        error_count  = 0;
        cycle_count  = 0;
        quiet_mode   = 1'b0;
        hold_off_req = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i]   = 1'b0;
            slot_pinned[i] = 1'b0;
            slot_pos[i]    = '0;
            slot_owner[i]  = '0;
            slot_sound[i]  = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_free_starts();
        test_stealing();
        test_stop_by_id();
        test_set_cursor();
        test_refusal();
        test_output_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
